### design/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Types and constants shared by the pulse rate detector modules.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 10;
  localparam int PERIOD_W  = 8;
  localparam int COUNT_W   = 16;
  localparam int PROD_W    = COUNT_W + PERIOD_W;
  localparam int QUOT_W    = 16;
  localparam int AVG_SUM_W = SAMPLE_W + 5;
  localparam int AVG_REM_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [QUOT_W-1:0]    RATE_NUMERATOR = 16'd60000;
  localparam logic [AVG_REM_W:0]   AVG_DIVISOR    = 6'd20;
  localparam logic [COUNT_W-1:0]   COUNT_MAX      = 16'hFFFF;

  localparam logic [PERIOD_W-1:0]  PERIOD_RST     = 8'd10;
  localparam logic [SAMPLE_W-1:0]  FLOOR_RST      = 16'd15000;
  localparam logic [SAMPLE_W-1:0]  MARGIN_RST     = 16'd150;
  localparam logic [RATE_W-1:0]    RATE_LOW_RST   = 10'd35;
  localparam logic [RATE_W-1:0]    RATE_HIGH_RST  = 10'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD    = 3'd0,
    REG_FLOOR     = 3'd1,
    REG_MARGIN    = 3'd2,
    REG_RATE_LOW  = 3'd3,
    REG_RATE_HIGH = 3'd4
  } prd_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ir_sample;
    logic                read_error;
  } prd_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_bpm;
    logic              beat_seen;
  } prd_out_t;

endpackage

### design/prd_avg_div.sv
// ----------------------------------------------------------------------------
// prd_avg_div
// Average update: forms 19*avg + sample, then divides by 20 one bit per cycle.
// ----------------------------------------------------------------------------
module prd_avg_div
  import prd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] avg,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                done,
  output logic [SAMPLE_W-1:0] avg_next
);

  localparam int STEP_W = $clog2(AVG_SUM_W);

  logic [AVG_SUM_W-1:0] dvd_r, dvd_nxt;
  logic [AVG_REM_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r;
  logic                 done_r;
  logic [AVG_SUM_W-1:0] sum;
  logic [AVG_REM_W:0]   trial;
  logic                 ge;

  assign sum = (AVG_SUM_W'(avg) << 4) + (AVG_SUM_W'(avg) << 1)
             + AVG_SUM_W'(avg) + AVG_SUM_W'(sample);

  always_comb begin
    trial   = {rem_r, dvd_r[AVG_SUM_W-1]};
    ge      = (trial >= AVG_DIVISOR);
    rem_nxt = ge ? AVG_REM_W'(trial - AVG_DIVISOR) : trial[AVG_REM_W-1:0];
    dvd_nxt = {dvd_r[AVG_SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dvd_r  <= sum;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r  <= dvd_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(AVG_SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign avg_next = dvd_r[SAMPLE_W-1:0];

endmodule

### design/prd_serial_mult.sv
// ----------------------------------------------------------------------------
// prd_serial_mult
// Shift-add multiplier, sample count times period, one period bit per cycle.
// ----------------------------------------------------------------------------
module prd_serial_mult
  import prd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [COUNT_W-1:0]  count,
  input  logic [PERIOD_W-1:0] period,
  output logic                done,
  output logic [PROD_W-1:0]   product
);

  localparam int STEP_W = $clog2(PERIOD_W);

  logic [PROD_W-1:0]  p_r, p_nxt;
  logic [COUNT_W-1:0] mcand_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r;
  logic               done_r;
  logic [COUNT_W:0]   s;

  always_comb begin
    s     = {1'b0, p_r[PROD_W-1:PERIOD_W]} + {1'b0, (p_r[0] ? mcand_r : '0)};
    p_nxt = {s, p_r[PERIOD_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        step_r  <= '0;
        mcand_r <= count;
        p_r     <= {{COUNT_W{1'b0}}, period};
      end else if (busy_r) begin
        p_r    <= p_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(PERIOD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

### design/prd_rate_div.sv
// ----------------------------------------------------------------------------
// prd_rate_div
// Restoring divider, 60000 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prd_rate_div
  import prd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(QUOT_W);

  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] d_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [PROD_W:0]   trial;
  logic              ge;

  always_comb begin
    trial   = {rem_r, q_r[QUOT_W-1]};
    ge      = (trial >= {1'b0, d_r});
    rem_nxt = ge ? PROD_W'(trial - {1'b0, d_r}) : trial[PROD_W-1:0];
    q_nxt   = {q_r[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        q_r    <= RATE_NUMERATOR;
        rem_r  <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        q_r    <= q_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### design/pulse_rate_detector_core.sv
// ----------------------------------------------------------------------------
// pulse_rate_detector_core
// Beat detector and heart rate estimator on an infrared sample stream.
// ----------------------------------------------------------------------------
// One sample is worked on at a time and each gives one result; the next
// sample is taken only once the last result has been registered. A sample
// that carries a read error or lies below the signal floor skips the
// arithmetic and goes straight to the finish state. Any other sample waits
// on the 8-step shift-add multiply of count by period, then the 16-step rate
// division, before it reaches the finish state;
// the 21-step average division runs alongside them. A result that waits on
// out_ready holds back only the following result, not the next acceptance.
// The output register lets the next sample be accepted while a result waits.
// Configuration is always ready; write it only while no sample is in flight.
// ----------------------------------------------------------------------------
module pulse_rate_detector_core
  import prd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prd_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prd_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t state_r;

  logic [PERIOD_W-1:0] period_r;
  logic [SAMPLE_W-1:0] floor_r;
  logic [SAMPLE_W-1:0] margin_r;
  logic [RATE_W-1:0]   rate_low_r;
  logic [RATE_W-1:0]   rate_high_r;

  logic [SAMPLE_W-1:0] avg_r;
  logic                latched_r;
  logic [COUNT_W-1:0]  count_r;
  logic [RATE_W-1:0]   held_r;

  logic [SAMPLE_W-1:0] x_r;
  logic                skip_r;
  logic                avg_ok_r;
  logic                rate_ok_r;
  logic                out_valid_r;
  prd_out_t            out_data_r;

  logic                in_fire;
  logic                unit_start;
  logic                avg_done;
  logic [SAMPLE_W-1:0] avg_new;
  logic                mult_done;
  logic [PROD_W-1:0]   product;
  logic                div_done;
  logic [QUOT_W-1:0]   rate_q;
  logic                commit;
  logic                in_skip;

  logic                beat;
  logic                rate_ok;
  logic [RATE_W-1:0]   held_nxt;
  logic                latched_nxt;
  logic [COUNT_W-1:0]  count_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_skip    = in_data.read_error || (in_data.ir_sample < floor_r);
  assign unit_start = in_fire && !in_skip;
  assign commit     = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign cfg_ready  = 1'b1;

  prd_avg_div u_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (unit_start),
    .avg      (avg_r),
    .sample   (in_data.ir_sample),
    .done     (avg_done),
    .avg_next (avg_new)
  );

  prd_serial_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unit_start),
    .count   (count_r),
    .period  (period_r),
    .done    (mult_done),
    .product (product)
  );

  prd_rate_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mult_done),
    .divisor  (product),
    .done     (div_done),
    .quotient (rate_q)
  );

  always_comb begin
    beat    = !latched_r &&
              (({1'b0, x_r} + {1'b0, margin_r}) < {1'b0, avg_new});
    rate_ok = (product != '0) &&
              (rate_q > QUOT_W'(rate_low_r)) && (rate_q < QUOT_W'(rate_high_r));
    held_nxt    = held_r;
    latched_nxt = latched_r;
    count_nxt   = count_r;
    if (skip_r) begin
      held_nxt = '0;
      beat     = 1'b0;
    end else begin
      if (beat) begin
        if (rate_ok) begin
          held_nxt = rate_q[RATE_W-1:0];
        end
        count_nxt   = '0;
        latched_nxt = 1'b1;
      end
      if (x_r > avg_new) begin
        latched_nxt = 1'b0;
      end
      if (count_nxt != COUNT_MAX) begin
        count_nxt = count_nxt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      floor_r     <= FLOOR_RST;
      margin_r    <= MARGIN_RST;
      rate_low_r  <= RATE_LOW_RST;
      rate_high_r <= RATE_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PERIOD:    period_r    <= cfg_data[PERIOD_W-1:0];
        REG_FLOOR:     floor_r     <= cfg_data[SAMPLE_W-1:0];
        REG_MARGIN:    margin_r    <= cfg_data[SAMPLE_W-1:0];
        REG_RATE_LOW:  rate_low_r  <= cfg_data[RATE_W-1:0];
        REG_RATE_HIGH: rate_high_r <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      avg_r       <= '0;
      latched_r   <= 1'b0;
      count_r     <= '0;
      held_r      <= '0;
      avg_ok_r    <= 1'b0;
      rate_ok_r   <= 1'b0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (avg_done) begin
        avg_ok_r <= 1'b1;
      end
      if (div_done) begin
        rate_ok_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r       <= in_data.ir_sample;
            skip_r    <= in_skip;
            avg_ok_r  <= 1'b0;
            rate_ok_r <= 1'b0;
            state_r   <= in_skip ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          if (avg_ok_r && rate_ok_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit) begin
            held_r               <= held_nxt;
            latched_r            <= latched_nxt;
            count_r              <= count_nxt;
            if (!skip_r) begin
              avg_r <= avg_new;
            end
            out_data_r.rate_bpm  <= held_nxt;
            out_data_r.beat_seen <= beat;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("sample accepted while another is in flight");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> state_r == S_FIN)
    else $error("result finished while output still occupied");

  a_beat_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !skip_r && beat) |=> (latched_r && count_r == COUNT_W'(1)))
    else $error("beat did not disarm and restart the count");

  a_skip_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && skip_r) |=> (held_r == '0 && !out_data_r.beat_seen))
    else $error("rejected sample did not clear the rate");

endmodule

### test/prd_rate_checker.sv
// ----------------------------------------------------------------------------
// prd_rate_checker
// Tracks register writes and accepted samples and predicts the rate and
// beat flag of each result. Every result beat is compared in order with its
// prediction. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module prd_rate_checker
  import prd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  prd_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  prd_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AVG_OLD_WEIGHT = 19;
  localparam int          MAX_REPORTS    = 50;

  logic [PERIOD_W-1:0] period_cfg;
  logic [SAMPLE_W-1:0] floor_cfg;
  logic [SAMPLE_W-1:0] margin_cfg;
  logic [RATE_W-1:0]   low_cfg;
  logic [RATE_W-1:0]   high_cfg;

  logic [SAMPLE_W-1:0] avg_level;
  logic                disarmed;
  logic [COUNT_W-1:0]  beat_interval;
  logic [RATE_W-1:0]   held_bpm;

  prd_out_t expected_results[$];
  int       errors;

  initial begin
    errors          = 0;
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < MAX_REPORTS)
      $display("%0t: mismatch on %s: got %0d, predicted %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic prd_out_t predict_rate(input prd_in_t s);
    prd_out_t    res;
    int unsigned avg_next;
    int unsigned divisor;
    int unsigned quot;
    logic        beat;
    beat = 1'b0;
    if (s.read_error || s.ir_sample < floor_cfg) begin
      held_bpm = '0;
    end else begin
      avg_next  = (AVG_OLD_WEIGHT * avg_level + s.ir_sample) / AVG_DIVISOR;
      avg_level = avg_next[SAMPLE_W-1:0];
      if (!disarmed && int'(s.ir_sample) + int'(margin_cfg) < int'(avg_level)) begin
        beat    = 1'b1;
        divisor = beat_interval * period_cfg;
        if (divisor != 0) begin
          quot = RATE_NUMERATOR / divisor;
          if (quot > low_cfg && quot < high_cfg)
            held_bpm = quot[RATE_W-1:0];
        end
        beat_interval = '0;
        disarmed      = 1'b1;
      end
      if (s.ir_sample > avg_level)
        disarmed = 1'b0;
      if (beat_interval != COUNT_MAX)
        beat_interval++;
    end
    res.rate_bpm  = held_bpm;
    res.beat_seen = beat;
    return res;
  endfunction

  always @(posedge clk) begin
    prd_out_t want;
    if (!rst_n) begin
      period_cfg    = PERIOD_RST;
      floor_cfg     = FLOOR_RST;
      margin_cfg    = MARGIN_RST;
      low_cfg       = RATE_LOW_RST;
      high_cfg      = RATE_HIGH_RST;
      avg_level     = '0;
      disarmed      = 1'b0;
      beat_interval = '0;
      held_bpm      = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", out_data.rate_bpm, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.rate_bpm !== want.rate_bpm)
            report_mismatch("rate_bpm", out_data.rate_bpm, want.rate_bpm);
          if (out_data.beat_seen !== want.beat_seen)
            report_mismatch("beat_seen", out_data.beat_seen, want.beat_seen);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (prd_reg_t'(cfg_index))
          REG_PERIOD:    period_cfg = cfg_data[PERIOD_W-1:0];
          REG_FLOOR:     floor_cfg  = cfg_data[SAMPLE_W-1:0];
          REG_MARGIN:    margin_cfg = cfg_data[SAMPLE_W-1:0];
          REG_RATE_LOW:  low_cfg    = cfg_data[RATE_W-1:0];
          REG_RATE_HIGH: high_cfg   = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_rate(in_data));
    end
    fail_count      <= errors;
    pending_results <= expected_results.size();
  end

endmodule

### test/pulse_rate_detector_core_tb.sv
// ----------------------------------------------------------------------------
// pulse_rate_detector_core_tb
// Drives sample beats and register writes into the pulse rate detector.
// A directed pass covers floor, error, zero period, oversized rate and empty
// band cases; random segments then send pulse trains with random content
// under several register settings and idle patterns. The checker predicts
// each result; the verdict depends on its mismatch count.
// ----------------------------------------------------------------------------
module pulse_rate_detector_core_tb
  import prd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   STALL_LIMIT     = 2000;
  localparam int                   SETTLE_CYCLES   = 40;
  localparam int                   SEGMENTS        = 12;
  localparam int                   SEGMENT_ITEMS   = 86;
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd5;
  localparam int unsigned          SAMPLE_MAX      = 2**SAMPLE_W - 1;
  localparam int unsigned          RATE_MAX        = 2**RATE_W - 1;
  localparam int unsigned          PERIOD_MAX      = 2**PERIOD_W - 1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  prd_in_t              in_data   = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  prd_out_t             out_data;

  int fail_count;
  int pending_results;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  int unsigned cur_period;
  int unsigned cur_floor;
  int unsigned cur_margin;
  int unsigned cur_low;
  int unsigned cur_high;

  pulse_rate_detector_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  prd_rate_checker rate_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_sample(input int unsigned x, input logic err);
    prd_in_t item;
    int      gap;
    item.ir_sample  = x[SAMPLE_W-1:0];
    item.read_error = err;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DAT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input int unsigned period, input int unsigned floor_lvl,
                            input int unsigned margin, input int unsigned low,
                            input int unsigned high);
    write_reg(REG_PERIOD, period);
    write_reg(REG_FLOOR, floor_lvl);
    write_reg(REG_MARGIN, margin);
    write_reg(REG_RATE_LOW, low);
    write_reg(REG_RATE_HIGH, high);
    cfg_valid <= 1'b0;
    cur_period = period;
    cur_floor  = floor_lvl;
    cur_margin = margin;
    cur_low    = low;
    cur_high   = high;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned x;
    int unsigned depth;
    int unsigned baseline;
    int unsigned until_dip;
    int unsigned lo;
    int unsigned target;
    int unsigned span;
    int          r;
    logic        err;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 61;
    set_config(PERIOD_RST, FLOOR_RST, MARGIN_RST, RATE_LOW_RST, RATE_HIGH_RST);
    // spare indexes must not land on any register
    for (int i = FIRST_SPARE_REG; i < 2**CFG_IDX_W; i++)
      write_reg(i[CFG_IDX_W-1:0], SAMPLE_MAX);
    cfg_valid <= 1'b0;

    // floor and read error handling at field extremes
    send_sample(0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(FLOOR_RST - 1, 1'b0);
    send_sample(FLOOR_RST, 1'b0);

    // zero period: beats without a rate
    wait_drained();
    set_config(0, 0, 0, 0, RATE_MAX);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);

    // quotient far above the rate field
    wait_drained();
    set_config(1, 0, 0, 0, RATE_MAX);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);

    // longest period, accepted rate
    wait_drained();
    set_config(PERIOD_MAX, 0, 0, 0, RATE_MAX);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);

    // empty band
    wait_drained();
    set_config(PERIOD_MAX, 0, 0, 100, 101);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);

    // margin too wide for any beat
    wait_drained();
    set_config(PERIOD_RST, 0, SAMPLE_MAX, 0, RATE_MAX);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case (seg / 4)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: set_config(PERIOD_RST, FLOOR_RST, MARGIN_RST, RATE_LOW_RST, RATE_HIGH_RST);
        1: set_config(1, 0, 0, 0, RATE_MAX);
        2: set_config(PERIOD_MAX, SAMPLE_MAX, SAMPLE_MAX, RATE_MAX, RATE_MAX);
        3: set_config(0, 0, 100, 0, RATE_MAX);
        default: begin
          lo = $urandom_range(150, 0);
          set_config($urandom_range(PERIOD_MAX, 1), $urandom_range(30000, 0),
                     $urandom_range(3000, 0), lo, lo + $urandom_range(200, 2));
        end
      endcase
      lo        = (cur_floor + 2000 > SAMPLE_MAX) ? SAMPLE_MAX : cur_floor + 2000;
      baseline  = $urandom_range(SAMPLE_MAX, lo);
      until_dip = $urandom_range(60, 20);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        r   = $urandom_range(99, 0);
        err = 1'b0;
        if (r < 4) begin
          x   = $urandom_range(SAMPLE_MAX, 0);
          err = 1'b1;
        end else if (r < 10) begin
          x = $urandom_range(SAMPLE_MAX, 0);
        end else if (until_dip == 0) begin
          depth     = cur_margin + $urandom_range(3000, 1);
          x         = (baseline > depth) ? baseline - depth : 0;
          lo        = (cur_low > 10) ? cur_low - 10 : 1;
          target    = $urandom_range(cur_high + 10, lo);
          span      = RATE_NUMERATOR / (target * ((cur_period == 0) ? 1 : cur_period));
          until_dip = (span < 2) ? 1 : (span > 300) ? 299 : span - 1;
        end else begin
          x = baseline + $urandom_range(300, 0);
          if (x > SAMPLE_MAX)
            x = SAMPLE_MAX;
          until_dip--;
        end
        send_sample(x, err);
      end
    end

    wait_drained();
    if (fail_count == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
